[hw/rtl/dsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared widths, register codes and pipeline slot types of the delta decoder.
// ----------------------------------------------------------------------------
package dsd_pkg;

   // channel storage
   localparam int MAX_CHANNELS = 64;
   localparam int CHAN_W       = 6;
   localparam int COUNT_W      = 7;

   // datapath widths
   localparam int CODE_W       = 8;
   localparam int DELTA_W      = 12;
   localparam int SUM_W        = 32;
   localparam int SCALE_W      = 24;
   localparam int FRAC_W       = 16;
   localparam int SCALED_W     = 40;
   localparam int PROD_W       = SUM_W + SCALE_W + 1;

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR  = 2'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

   // exponent code that selects the fine step (arithmetic shift right)
   localparam logic [1:0] EXP_CODE_FINE = 2'd3;

   // saturation limits of a running sum
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // one slot of the cell chain
   typedef struct packed {
      logic                      valid;
      logic [CHAN_W-1:0]         chan;
      logic                      last;
      logic signed [DELTA_W-1:0] delta;
      logic signed [SUM_W-1:0]   sum;
   } slot_type;

   // one finished result
   typedef struct packed {
      logic [CHAN_W-1:0]          chan;
      logic signed [SUM_W-1:0]    raw;
      logic signed [SCALED_W-1:0] scaled;
      logic                       last;
   } result_type;

endpackage

[hw/rtl/multichannel_delta_sample_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_delta_sample_decoder
// Delta decoder for round-robin interleaved coded bytes with per-channel
// saturating sums and a Q8.16 gain on every result.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the chain moves and gives one result.
// Each byte travels down a chain of 64 channel cells, one cell per cycle
// while the chain moves; the cell that owns the byte's channel adds the
// delta to its sum, so back-to-back bytes of the same channel are handled in
// order with no forwarding. The gain multiply adds one stage before the
// result queue. A two-entry result queue lets the chain keep moving while a
// result waits; the chain only halts once both entries are full.
// The configuration port is always ready and should be written while idle.
// ----------------------------------------------------------------------------
module multichannel_delta_sample_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dsd_pkg::CODE_W-1:0]          req_code_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dsd_pkg::CHAN_W-1:0]          rsp_channel_index,
   output logic signed [dsd_pkg::SUM_W-1:0]    rsp_raw_sample,
   output logic signed [dsd_pkg::SCALED_W-1:0] rsp_scaled_sample,
   output logic                                rsp_scan_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dsd_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dsd_pkg::*;

   logic [COUNT_W-1:0] channel_count_ff;
   logic [SCALE_W-1:0] scale_factor_ff;
   logic               advance;
   slot_type           slots [MAX_CHANNELS+1];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= COUNT_RESET;
         scale_factor_ff  <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[COUNT_W-1:0];
            CSR_SCALE_FACTOR:  scale_factor_ff  <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = advance;

   // position counter and decode
   dsd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .advance       (advance),
      .req_code_byte (req_code_byte),
      .channel_count (channel_count_ff),
      .slot_out      (slots[0])
   );

   // chain of channel cells
   for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_cell
      dsd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (CHAN_W'(k)),
         .slot_in    (slots[k]),
         .slot_out   (slots[k+1])
      );
   end

   // gain stage and result queue
   dsd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .slot_in           (slots[MAX_CHANNELS]),
      .scale_factor      (scale_factor_ff),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_sample    (rsp_raw_sample),
      .rsp_scaled_sample (rsp_scaled_sample),
      .rsp_scan_last     (rsp_scan_last)
   );

endmodule

[hw/rtl/dsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_front
// Round-robin channel position and delta decode of the incoming coded byte.
// ----------------------------------------------------------------------------
module dsd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           advance,
   input  logic [dsd_pkg::CODE_W-1:0]     req_code_byte,
   input  logic [dsd_pkg::COUNT_W-1:0]    channel_count,
   output dsd_pkg::slot_type              slot_out
);
   import dsd_pkg::*;

   logic [CHAN_W-1:0]         position_ff;
   logic [CHAN_W-1:0]         position_in;
   logic [COUNT_W-1:0]        count_eff;
   logic [COUNT_W-1:0]        position_inc;
   logic                      last;
   logic signed [CODE_W-1:0]  byte_s;
   logic signed [CODE_W-1:0]  byte_masked;
   logic signed [DELTA_W-1:0] delta_base;
   logic signed [DELTA_W-1:0] delta;
   logic [1:0]                exp_code;

   // clamp the channel count into one to the channel maximum
   always_comb begin
      if (channel_count == '0) begin
         count_eff = COUNT_W'(1);
      end else if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
         count_eff = COUNT_W'(MAX_CHANNELS);
      end else begin
         count_eff = channel_count;
      end
   end

   // scan end and next position
   assign position_inc = {1'b0, position_ff} + COUNT_W'(1);
   assign last         = (position_inc >= count_eff);
   assign position_in  = last ? '0 : position_inc[CHAN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else if (req_valid && advance) begin
         position_ff <= position_in;
      end
   end

   // delta decode: fine step shifts right, coarse steps clear the code bits
   // and shift left by twice the code
   assign byte_s      = signed'(req_code_byte);
   assign exp_code    = req_code_byte[1:0];
   assign byte_masked = signed'({req_code_byte[CODE_W-1:2], 2'b00});
   assign delta_base  = DELTA_W'(byte_masked);

   always_comb begin
      if (exp_code == EXP_CODE_FINE) begin
         delta = DELTA_W'(byte_s >>> 2);
      end else begin
         delta = delta_base <<< {exp_code, 1'b0};
      end
   end

   // slot entering the first cell
   always_comb begin
      slot_out.valid = req_valid;
      slot_out.chan  = position_ff;
      slot_out.last  = last;
      slot_out.delta = delta;
      slot_out.sum   = '0;
   end

endmodule

[hw/rtl/dsd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_cell
// One channel cell: holds that channel's running sum and passes the slot on.
// ----------------------------------------------------------------------------
module dsd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [dsd_pkg::CHAN_W-1:0]  cell_index,
   input  dsd_pkg::slot_type           slot_in,
   output dsd_pkg::slot_type           slot_out
);
   import dsd_pkg::*;

   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W:0]   sum_wide;
   logic                    hit;
   slot_type                slot_ff;
   slot_type                slot_in_mod;

   assign hit = slot_in.valid && (slot_in.chan == cell_index);

   // saturating add of the delta
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} + (SUM_W+1)'(slot_in.delta);

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (advance && hit) begin
         sum_ff <= sum_in;
      end
   end

   // the owning cell writes its new sum into the passing slot
   always_comb begin
      slot_in_mod = slot_in;
      if (hit) begin
         slot_in_mod.sum = sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_in_mod;
      end
   end

   assign slot_out = slot_ff;

endmodule

[hw/rtl/dsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_back
// Gain multiply stage and two-entry result queue at the end of the chain.
// ----------------------------------------------------------------------------
module dsd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  dsd_pkg::slot_type                   slot_in,
   input  logic [dsd_pkg::SCALE_W-1:0]         scale_factor,
   output logic                                advance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dsd_pkg::CHAN_W-1:0]          rsp_channel_index,
   output logic signed [dsd_pkg::SUM_W-1:0]    rsp_raw_sample,
   output logic signed [dsd_pkg::SCALED_W-1:0] rsp_scaled_sample,
   output logic                                rsp_scan_last
);
   import dsd_pkg::*;

   logic signed [SUM_W-1:0]     mul_a;
   logic signed [SCALE_W:0]     mul_b;
   logic signed [PROD_W-1:0]    prod;
   logic                        mul_valid_ff;
   logic [CHAN_W-1:0]           mul_chan_ff;
   logic signed [SUM_W-1:0]     mul_raw_ff;
   logic                        mul_last_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   result_type                  entry_ff [2];
   result_type                  push_data;
   logic                        wr_ptr_ff;
   logic                        rd_ptr_ff;
   logic [1:0]                  count_ff;
   logic [1:0]                  count_in;
   logic                        push;
   logic                        pop;

   // chain moves while the queue has room
   assign advance = (count_ff != 2'd2);

   // signed sum times unsigned gain
   assign mul_a = slot_in.sum;
   assign mul_b = signed'({1'b0, scale_factor});
   assign prod  = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= slot_in.valid;
         mul_chan_ff  <= slot_in.chan;
         mul_raw_ff   <= slot_in.sum;
         mul_last_ff  <= slot_in.last;
         prod_ff      <= prod;
      end
   end

   // result word, product shifted right by the fraction bits
   always_comb begin
      push_data.chan   = mul_chan_ff;
      push_data.raw    = mul_raw_ff;
      push_data.scaled = prod_ff[FRAC_W+SCALED_W-1:FRAC_W];
      push_data.last   = mul_last_ff;
   end

   assign push = advance && mul_valid_ff;
   assign pop  = rsp_valid && rsp_ready;

   // queue occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // head of queue drives the result channel
   assign rsp_valid         = (count_ff != 2'd0);
   assign rsp_channel_index = entry_ff[rd_ptr_ff].chan;
   assign rsp_raw_sample    = entry_ff[rd_ptr_ff].raw;
   assign rsp_scaled_sample = entry_ff[rd_ptr_ff].scaled;
   assign rsp_scan_last     = entry_ff[rd_ptr_ff].last;

endmodule

[hw/rtl/dsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_checker
// Port-level checks of the delta decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dsd_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [dsd_pkg::CHAN_W-1:0]          rsp_channel_index,
   input  logic signed [dsd_pkg::SUM_W-1:0]    rsp_raw_sample,
   input  logic signed [dsd_pkg::SCALED_W-1:0] rsp_scaled_sample,
   input  logic                                rsp_scan_last
);
   import dsd_pkg::*;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_index)
         && $stable(rsp_raw_sample) && $stable(rsp_scaled_sample)
         && $stable(rsp_scan_last))
      else $error("stalled result changed");

   // zero sum scales to zero
   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_raw_sample == '0) |-> (rsp_scaled_sample == '0))
      else $error("zero sum gave nonzero scaled value");

   // unsigned gain keeps the sign of a non-negative sum
   a_sign_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_raw_sample[SUM_W-1] |-> !rsp_scaled_sample[SCALED_W-1])
      else $error("scaled value negative for non-negative sum");

endmodule

bind multichannel_delta_sample_decoder dsd_checker u_checker (.*);

[tb/sv/tb_multichannel_delta_sample_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_delta_sample_decoder
// Self-checking bench for the interleaved delta sample decoder. A scoreboard
// keeps its own copy of the per-channel sums, scan position and registers,
// predicts every result from the accepted bytes and compares it field by
// field with what the block returns. Stimulus runs corner bytes, a count cut
// in the middle of a scan, a steep downward run of one sum at full gain, and
// random phases under changing register settings, sender gaps and receiver
// stall patterns.
// ----------------------------------------------------------------------------
module tb_multichannel_delta_sample_decoder;
   import dsd_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int IDLE_LIMIT  = 4000;
   localparam int PHASES      = 11;
   localparam int PHASE_BYTES = 145;
   localparam int TAIL_CYCLES = 80;
   localparam int STEEP_RUN   = 24;

   // register indexes that the block does not implement
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;

   localparam logic [SCALE_W-1:0] SCALE_ZERO = 24'd0;
   localparam logic [SCALE_W-1:0] SCALE_FULL = 24'hFFFFFF;

   // steepest negative delta: code 2 on the most negative byte that carries it
   localparam logic [CODE_W-1:0] STEEPEST_DOWN = 8'h82;

   // extremes of the signed byte under every exponent code
   localparam logic [CODE_W-1:0] CORNER_BYTES [13] = '{
      8'h00, 8'hFF, 8'h7F, 8'h80, 8'h7C, 8'h81, 8'h7D,
      8'h82, 8'h7E, 8'h83, 8'h01, 8'h02, 8'h03
   };

   // large steps in both directions after the downward run
   localparam logic [CODE_W-1:0] SWING_BYTES [8] = '{
      8'h7E, 8'h7E, 8'h03, 8'hFF, 8'h82, 8'h82, 8'h83, 8'h82
   };

   typedef enum logic [1:0] {RECV_READY, RECV_MASK, RECV_RANDOM} recv_mode_type;

   // --------------------------------------------------------------------------
   // scoreboard: running sums, scan position and registers of the block
   // --------------------------------------------------------------------------
   class dsd_sum_tracker;
      int                 sums [MAX_CHANNELS];
      int unsigned        position;
      logic [COUNT_W-1:0] count;
      logic [SCALE_W-1:0] gain;
      result_type         pending [$];
      int                 errors;
      int                 checked;

      function new();
         foreach (sums[k]) sums[k] = 0;
         position = 0;
         count    = COUNT_RESET;
         gain     = SCALE_RESET;
         errors   = 0;
         checked  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CHANNEL_COUNT: count = data[COUNT_W-1:0];
            CSR_SCALE_FACTOR:  gain  = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      // fine code shifts right, the others clear the code bits and shift left
      function int byte_to_delta(logic [CODE_W-1:0] code_byte);
         int s;
         s = int'($signed(code_byte));
         if (code_byte[1:0] == EXP_CODE_FINE) return s >>> 2;
         s = s - int'(code_byte[1:0]);
         return s <<< (2 * code_byte[1:0]);
      endfunction

      function void take_byte(logic [CODE_W-1:0] code_byte);
         int unsigned n;
         int unsigned pos;
         longint      total;
         longint      product;
         longint      shifted;
         result_type  r;
         n = count;
         if (n < 1) n = 1;
         if (n > MAX_CHANNELS) n = MAX_CHANNELS;
         pos = (position >= MAX_CHANNELS) ? 0 : position;
         total = longint'(sums[pos]) + longint'(byte_to_delta(code_byte));
         if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
         if (total < longint'(SUM_MIN)) total = longint'(SUM_MIN);
         sums[pos] = int'(total);
         product   = total * longint'({40'd0, gain});
         shifted   = product >>> FRAC_W;
         r.chan    = pos[CHAN_W-1:0];
         r.raw     = total[SUM_W-1:0];
         r.scaled  = shifted[SCALED_W-1:0];
         r.last    = (pos + 1 >= n);
         position  = r.last ? 0 : pos + 1;
         pending.push_back(r);
      endfunction

      function void report(string field, longint want, longint got);
         errors++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_result(logic [CHAN_W-1:0] chan, logic signed [SUM_W-1:0] raw,
                                 logic signed [SCALED_W-1:0] scaled, logic last);
         result_type want;
         if (pending.size() == 0) begin
            errors++;
            $error("result for channel %0d with no byte outstanding", chan);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (chan !== want.chan)     report("channel_index", want.chan, chan);
         if (raw !== want.raw)       report("raw_sample", want.raw, raw);
         if (scaled !== want.scaled) report("scaled_sample", want.scaled, scaled);
         if (last !== want.last)     report("scan_last", want.last, last);
      endfunction
   endclass

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic [CODE_W-1:0]     req_code_byte = '0;
   logic                  rsp_ready     = 1'b0;
   logic                  csr_valid     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_data      = '0;

   logic                       req_ready;
   logic                       rsp_valid;
   logic [CHAN_W-1:0]          rsp_channel_index;
   logic signed [SUM_W-1:0]    rsp_raw_sample;
   logic signed [SCALED_W-1:0] rsp_scaled_sample;
   logic                       rsp_scan_last;
   logic                       csr_ready;

   dsd_sum_tracker tracker = new();

   recv_mode_type recv_mode   = RECV_READY;
   logic [15:0]   recv_mask   = 16'hFFFF;
   logic [3:0]    mask_step   = '0;
   int            hold_left   = 0;
   bit            gap_enable  = 1'b0;
   int            burst_left  = 0;
   int            idle_cycles = 0;
   int            reg_writes  = 0;
   int            bytes_sent  = 0;

   multichannel_delta_sample_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_byte     (req_code_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_sample    (rsp_raw_sample),
      .rsp_scaled_sample (rsp_scaled_sample),
      .rsp_scan_last     (rsp_scan_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // observe every transfer on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_data);
         if (req_valid && req_ready) tracker.take_byte(req_code_byte);
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_channel_index, rsp_raw_sample, rsp_scaled_sample,
                                 rsp_scan_last);
      end
   end

   // receiver stalls: always ready, a rotating mask, or random with long holds
   always @(posedge clock) begin
      if (recv_mode == RECV_READY) begin
         rsp_ready <= 1'b1;
      end else if (recv_mode == RECV_MASK) begin
         rsp_ready <= recv_mask[mask_step];
         mask_step <= mask_step + 4'd1;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if ($urandom_range(0, 63) == 0) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(1, 30);
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("multichannel_delta_sample_decoder regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one byte transfer, with burst gaps when enabled
   task automatic send_byte(input logic [CODE_W-1:0] code_byte);
      int gap;
      if (gap_enable) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_code_byte <= code_byte;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // hold the sender until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      @(posedge clock);
   endtask

   function automatic logic [CODE_W-1:0] random_code_byte();
      logic [CODE_W-1:0] b;
      b = CODE_W'($urandom);
      // lean toward the coarse code so sums wander far
      if ($urandom_range(0, 4) == 0) b[1:0] = 2'd2;
      return b;
   endfunction

   // stimulus
   initial begin
      int                  phase;
      int                  k;
      logic [COUNT_W-1:0]  count_val;
      logic [CSR_DATA_W-1:0] word;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner bytes on the single reset channel
      foreach (CORNER_BYTES[j]) send_byte(CORNER_BYTES[j]);
      drain();

      // count lowered while the scan position is past the new end
      write_reg(CSR_CHANNEL_COUNT, 24'(MAX_CHANNELS));
      for (k = 0; k < 10; k++) send_byte(CODE_W'($urandom));
      drain();
      write_reg(CSR_CHANNEL_COUNT, 24'd4);
      for (k = 0; k < 2; k++) send_byte(CODE_W'($urandom));
      drain();

      // steep downward run of channel 0 at full gain, then large swings
      write_reg(CSR_CHANNEL_COUNT, 24'd1);
      write_reg(CSR_SCALE_FACTOR, SCALE_FULL);
      for (k = 0; k < STEEP_RUN; k++) send_byte(STEEPEST_DOWN);
      foreach (SWING_BYTES[j]) send_byte(SWING_BYTES[j]);
      drain();

      // random phases under changing settings and handshake pressure
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: count_val = 7'd0;
            1: count_val = 7'd127;
            2: count_val = 7'(MAX_CHANNELS);
            3: count_val = 7'd1;
            default:
               case ($urandom_range(0, 5))
                  0:       count_val = 7'd0;
                  1:       count_val = 7'($urandom_range(65, 127));
                  2:       count_val = 7'(MAX_CHANNELS);
                  default: count_val = 7'($urandom_range(1, 16));
               endcase
         endcase
         word = CSR_DATA_W'($urandom);
         word[COUNT_W-1:0] = count_val;
         write_reg(CSR_CHANNEL_COUNT, word);

         case (phase)
            0: word = SCALE_ZERO;
            1: word = SCALE_FULL;
            2: word = SCALE_RESET;
            default:
               case ($urandom_range(0, 4))
                  0:       word = SCALE_ZERO;
                  1:       word = SCALE_FULL;
                  2:       word = SCALE_RESET;
                  default: word = CSR_DATA_W'($urandom);
               endcase
         endcase
         write_reg(CSR_SCALE_FACTOR, word);

         if (phase < 2 || $urandom_range(0, 3) == 0)
            write_reg(phase[0] ? CSR_UNUSED_B : CSR_UNUSED_A, CSR_DATA_W'($urandom));

         case (phase)
            0:       recv_mode = RECV_READY;
            1:       recv_mode = RECV_MASK;
            2:       recv_mode = RECV_RANDOM;
            default: recv_mode = recv_mode_type'($urandom_range(0, 2));
         endcase
         recv_mask  = 16'($urandom) | 16'h0001;
         gap_enable = (phase != 0) && ($urandom_range(0, 3) != 0);
         burst_left = 0;

         for (k = 0; k < PHASE_BYTES; k++) send_byte(random_code_byte());
         drain();
      end

      // let any stray result surface before the verdict
      recv_mode = RECV_READY;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.pending.size() != 0) begin
         tracker.errors++;
         $error("%0d predicted results never arrived", tracker.pending.size());
      end

      $display("covered %0d bytes and %0d register writes, %0d results compared",
               bytes_sent, reg_writes, tracker.checked);
      $display("counts from zero to above the channel limit, gain from zero to full scale, "
               , "one sum stepped steeply down and back");
      if (tracker.errors == 0)
         $display("multichannel_delta_sample_decoder regression: pass");
      else
         $display("multichannel_delta_sample_decoder regression: fail");
      $finish;
   end

endmodule
